>>> hw/rtl/sre_pkg.sv
// ============================================================================
// Sobel RGB edge filter package
// Shared sizes, register codes, payload types and the Sobel magnitude math.
// ============================================================================
package sre_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 4;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int LINE_W = 2 * PIX_W;
    localparam int GRAD_W = CHAN_W + 4;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    localparam int RES_FIFO_DEPTH = 8;
    localparam int PTR_W          = $clog2(RES_FIFO_DEPTH);
    localparam int LVL_W          = $clog2(RES_FIFO_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(255);

    localparam int CH_RED   = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 0;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0]  pixel_t;

    // top: two rows above, mid: one row above, bot: current row
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        chan_t edge_red;
        chan_t edge_green;
        chan_t edge_blue;
        logic  frame_end;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic signed [GRAD_W-1:0] chan_ext(input pixel_t p, input int k);
        return $signed(GRAD_W'(p[k*CHAN_W +: CHAN_W]));
    endfunction

    function automatic chan_t sobel_mag(input column_t l, input column_t c,
                                        input column_t r, input int k);
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [GRAD_W-1:0]        ax;
        logic [GRAD_W-1:0]        ay;
        logic [GRAD_W:0]          sum;
        logic [GRAD_W-1:0]        half;
        gx = (chan_ext(r.top, k) - chan_ext(l.top, k))
           + ((chan_ext(r.mid, k) - chan_ext(l.mid, k)) <<< 1)
           + (chan_ext(r.bot, k) - chan_ext(l.bot, k));
        gy = (chan_ext(l.bot, k) + (chan_ext(c.bot, k) <<< 1) + chan_ext(r.bot, k))
           - (chan_ext(l.top, k) + (chan_ext(c.top, k) <<< 1) + chan_ext(r.top, k));
        ax   = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
        ay   = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
        sum  = {1'b0, ax} + {1'b0, ay};
        half = sum[GRAD_W:1];
        return (half > GRAD_W'(CHAN_MAX)) ? CHAN_MAX : half[CHAN_W-1:0];
    endfunction

    function automatic result_t edge_result(input column_t l, input column_t c,
                                            input column_t r, input logic last);
        result_t res;
        res.edge_red   = sobel_mag(l, c, r, CH_RED);
        res.edge_green = sobel_mag(l, c, r, CH_GREEN);
        res.edge_blue  = sobel_mag(l, c, r, CH_BLUE);
        res.frame_end  = last;
        return res;
    endfunction

endpackage

>>> hw/rtl/sre_ram.sv
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data (old data on collision).
// ============================================================================
module sre_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/sre_result_fifo.sv
// ============================================================================
// Result buffer
// Small FIFO taking zero, one or two results per cycle, one out per cycle on out_ready.
// ============================================================================
module sre_result_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sre_pkg::push_t           push,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sre_pkg::result_t         out_data,
    output logic [sre_pkg::LVL_W-1:0] level
);
    import sre_pkg::*;

    result_t          store_reg [RES_FIFO_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [PTR_W-1:0] tail_inc;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = store_reg[head_reg];
    assign level     = level_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        tail_inc   = tail_reg + PTR_W'(1);
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.count);
        level_next = level_reg + LVL_W'(push.count) - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            store_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            store_reg[tail_inc] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

endmodule

>>> hw/rtl/sobel_rgb_edge_filter.sv
// ============================================================================
// Sobel RGB edge filter
// Streaming 3x3 Sobel on RGB pixels, two line stores in one RAM, 3x3 window.
// ============================================================================
//  Channel  Dir  Payload
//  s_*      in   req_type, pixel_red, pixel_green, pixel_blue
//  m_*      out  edge_red, edge_green, edge_blue, frame_end
//  cfg_*    in   cfg_index (0 image_width, 1 image_height), cfg_data
//
//  One pixel transaction per clock while s_ready is high; the line store RAM
//  does one read and one write per cycle. Results pass stages B and C and
//  the result buffer to m_*; a row's last item gives up to two results.
//  s_ready drops when the result buffer lacks room for two results per item
//  in flight. Reset clears position, window and registers; the line store
//  is not cleared. Same-column reads right after a write are forwarded.
// ============================================================================
module sobel_rgb_edge_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [7:0]                    s_pixel_red,
    input  logic [7:0]                    s_pixel_green,
    input  logic [7:0]                    s_pixel_blue,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_edge_red,
    output logic [7:0]                    m_edge_green,
    output logic [7:0]                    m_edge_blue,
    output logic                          m_frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sre_pkg::CFG_W-1:0]     cfg_data
);
    import sre_pkg::*;

    localparam int PEND_W = LVL_W + 2;

    logic             run_reg;
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;

    logic [COL_W-1:0] col_reg;
    logic [HGT_W-1:0] row_reg;
    logic [WID_W-1:0] col_plus1;
    logic             accept;
    logic             row_end;
    logic             row_over;
    pixel_t           px_a;

    // stage B: line store data arrives
    logic              b_valid_reg;
    logic [COL_W-1:0]  b_ci_reg;
    pixel_t            b_px_reg;
    logic              b_keep2_reg;
    logic              b_keep1_reg;
    logic              b_col0_reg;
    logic              b_mid_reg;
    logic              b_end_reg;
    logic              b_last_reg;
    logic              b_fwd_reg;
    logic [LINE_W-1:0] b_fwd_data_reg;
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_raw;
    logic [LINE_W-1:0] ram_wdata;
    column_t           newc;
    column_t           win_left_reg;
    column_t           win_ctr_reg;
    column_t           win_left_eff;
    column_t           win_ctr_eff;

    // stage C: gradient math
    logic    c_valid_reg;
    logic    c_mid_reg;
    logic    c_end_reg;
    logic    c_last_reg;
    column_t c_a_reg;
    column_t c_b_reg;
    column_t c_n_reg;
    result_t res_mid;
    result_t res_end;
    push_t   push;

    result_t          out_res;
    logic [LVL_W-1:0] fifo_level;
    logic [PEND_W-1:0] pend;

    // ---------------- configuration ----------------
    assign cfg_ready = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b0;
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else begin
            run_reg <= 1'b1;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WID_W'(1);
        end else if (int'(width_cfg_reg) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = HGT_W'(1);
        end else if (int'(height_cfg_reg) > MAX_HEIGHT) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(height_cfg_reg);
        end
    end

    // ---------------- stage A: accept, position, RAM read ----------------
    always_comb begin
        pend = PEND_W'(fifo_level) + PEND_W'(2)
             + (b_valid_reg ? PEND_W'(2) : PEND_W'(0))
             + (c_valid_reg ? PEND_W'(2) : PEND_W'(0));
    end

    assign s_ready   = run_reg && (pend <= PEND_W'(RES_FIFO_DEPTH));
    assign accept    = s_valid && s_ready;
    assign col_plus1 = WID_W'(col_reg) + WID_W'(1);
    assign row_end   = (col_plus1 >= w_eff);
    assign row_over  = (row_reg >= h_eff);
    assign px_a      = (s_req_type || row_over) ? '0
                     : {s_pixel_red, s_pixel_green, s_pixel_blue};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
            if (accept) begin
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_over ? '0 : row_reg + HGT_W'(1);
                end else begin
                    col_reg <= col_plus1[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_ci_reg       <= col_reg;
            b_px_reg       <= px_a;
            b_keep2_reg    <= (row_reg >= HGT_W'(2)) && (row_reg - HGT_W'(2) < h_eff);
            b_keep1_reg    <= (row_reg != '0) && (row_reg - HGT_W'(1) < h_eff);
            b_col0_reg     <= (col_reg == '0);
            b_mid_reg      <= (row_reg != '0) && (col_reg != '0);
            b_end_reg      <= (row_reg != '0) && row_end;
            b_last_reg     <= (row_reg == h_eff);
            b_fwd_reg      <= b_valid_reg && (b_ci_reg == col_reg);
            b_fwd_data_reg <= ram_wdata;
        end
    end

    sre_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (b_valid_reg),
        .waddr (b_ci_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ---------------- stage B: new column, write back, window ----------------
    always_comb begin
        line_raw     = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
        ram_wdata    = {line_raw[PIX_W-1:0], b_px_reg};
        newc.top     = b_keep2_reg ? line_raw[LINE_W-1:PIX_W] : '0;
        newc.mid     = b_keep1_reg ? line_raw[PIX_W-1:0] : '0;
        newc.bot     = b_px_reg;
        win_left_eff = b_col0_reg ? '0 : win_left_reg;
        win_ctr_eff  = b_col0_reg ? '0 : win_ctr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg <= '0;
            win_ctr_reg  <= '0;
            c_valid_reg  <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg) begin
                win_left_reg <= win_ctr_eff;
                win_ctr_reg  <= newc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            c_mid_reg  <= b_mid_reg;
            c_end_reg  <= b_end_reg;
            c_last_reg <= b_last_reg;
            c_a_reg    <= win_left_eff;
            c_b_reg    <= win_ctr_eff;
            c_n_reg    <= newc;
        end
    end

    // ---------------- stage C: gradients into result buffer ----------------
    always_comb begin
        res_mid     = edge_result(c_a_reg, c_b_reg, c_n_reg, 1'b0);
        res_end     = edge_result(c_b_reg, c_n_reg, '0, c_last_reg);
        push.count  = 2'd0;
        push.first  = res_mid;
        push.second = res_end;
        if (c_valid_reg) begin
            priority if (c_mid_reg && c_end_reg) begin
                push.count = 2'd2;
            end else if (c_mid_reg) begin
                push.count = 2'd1;
            end else if (c_end_reg) begin
                push.count = 2'd1;
                push.first = res_end;
            end
        end
    end

    sre_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res),
        .level     (fifo_level)
    );

    assign m_edge_red   = out_res.edge_red;
    assign m_edge_green = out_res.edge_green;
    assign m_edge_blue  = out_res.edge_blue;
    assign m_frame_end  = out_res.frame_end;

    // ---------------- checks ----------------
    a_buffer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level <= LVL_W'(RES_FIFO_DEPTH))
        else $error("result buffer overflow");

    a_accept_reaches_b: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> b_valid_reg)
        else $error("accepted transaction lost before stage B");

    a_fwd_with_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_fwd_reg) |-> $past(b_valid_reg))
        else $error("forwarding without a preceding item in stage B");

    a_mid_not_col0: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_mid_reg) |-> !b_col0_reg)
        else $error("window result requested at column zero");

    a_last_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ((push.count != 2'd0) && push.first.frame_end) |-> (c_end_reg && !c_mid_reg))
        else $error("frame end flagged away from a row end");

endmodule
